@@ rtl/assert_macros.svh @@
// Assertion helpers, clocked on clk and held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define RAU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define RAU_NEVER(lbl, expr, msg) \
  `RAU_ASSERT(lbl, !(expr), msg)

`endif

@@ rtl/rau_pkg.sv @@
package rau_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int NUM_W         = 32;
  localparam int DEN_W         = 31;
  localparam int OP_W          = 3;
  localparam int ERR_W         = 2;
  localparam int Q_DEPTH       = 2;

  typedef enum logic [OP_W-1:0] {
    OP_NORM = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_LESS = 3'd5,
    OP_EQ   = 3'd6,
    OP_NOP  = 3'd7
  } op_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK   = 2'd0,
    ERR_ZDEN = 2'd1,
    ERR_DIVZ = 2'd2,
    ERR_OVF  = 2'd3
  } err_t;

  typedef struct packed {
    op_t                     op;
    logic signed [NUM_W-1:0] a_num;
    logic signed [NUM_W-1:0] a_den;
    logic signed [NUM_W-1:0] b_num;
    logic        [DEN_W-1:0] b_den;
  } item_t;

  typedef struct packed {
    logic done;
    err_t err;
  } red_rsp_t;

  typedef enum logic [1:0] {
    R_IDLE,
    R_GCD,
    R_DIV,
    R_CHK
  } red_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_RA,
    B_RB,
    B_MUL,
    B_CMB,
    B_RR,
    B_OUT
  } back_state_t;

endpackage

@@ rtl/rau_if.sv @@
interface rau_in_if;
  logic                             valid;
  logic                             ready;
  logic        [rau_pkg::OP_W-1:0]  opcode;
  logic signed [rau_pkg::NUM_W-1:0] a_num;
  logic signed [rau_pkg::NUM_W-1:0] a_den;
  logic signed [rau_pkg::NUM_W-1:0] b_num;
  logic        [rau_pkg::DEN_W-1:0] b_den;

  modport source (output valid, opcode, a_num, a_den, b_num, b_den, input ready);
  modport sink   (input valid, opcode, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [rau_pkg::NUM_W-1:0] res_num;
  logic        [rau_pkg::DEN_W-1:0] res_den;
  logic                             compare_true;
  logic        [rau_pkg::ERR_W-1:0] error_code;

  modport source (output valid, res_num, res_den, compare_true, error_code, input ready);
  modport sink   (input valid, res_num, res_den, compare_true, error_code, output ready);
endinterface

@@ rtl/rau_front.sv @@
module rau_front #(
  parameter int WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
  rau_in_if.sink          in_ch,
  input  logic            full,
  output logic            push,
  output rau_pkg::item_t  item
);
  import rau_pkg::*;

  logic signed [WORD_BITS-1:0] an_w;
  logic signed [WORD_BITS-1:0] ad_w;
  logic signed [WORD_BITS-1:0] bn_w;

  assign in_ch.ready = !full;
  assign push        = in_ch.valid && !full;

  assign an_w = in_ch.a_num[WORD_BITS-1:0];
  assign ad_w = in_ch.a_den[WORD_BITS-1:0];
  assign bn_w = in_ch.b_num[WORD_BITS-1:0];

  always_comb begin
    item.op    = op_t'(in_ch.opcode);
    item.a_num = NUM_W'(an_w);
    item.a_den = NUM_W'(ad_w);
    item.b_num = NUM_W'(bn_w);
    item.b_den = DEN_W'(in_ch.b_den[WORD_BITS-2:0]);
  end

endmodule

@@ rtl/rau_fifo.sv @@
module rau_fifo #(
  parameter int DEPTH = rau_pkg::Q_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  rau_pkg::item_t  wdata,
  output logic            full,
  input  logic            pop,
  output rau_pkg::item_t  rdata,
  output logic            empty
);
  import rau_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t          mem_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

@@ rtl/rau_red.sv @@
module rau_red #(
  parameter int WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [2*WORD_BITS:0]        n_in,
  input  logic [2*WORD_BITS:0]        d_in,
  output rau_pkg::red_rsp_t           rsp,
  output logic signed [WORD_BITS-1:0] num,
  output logic [WORD_BITS-2:0]        den
);
  import rau_pkg::*;

  localparam int L  = 2 * WORD_BITS;
  localparam int NW = L + 1;
  localparam int KW = $clog2(L + 1);
  localparam int CW = $clog2(L);
  localparam logic [L-1:0] LIM = L'(1) << (WORD_BITS - 1);

  red_state_t                  st_r, st_nxt;
  logic                        neg_r, neg_nxt;
  logic [L-1:0]                u_r, u_nxt;
  logic [L-1:0]                v_r, v_nxt;
  logic [L-1:0]                mn_r, mn_nxt;
  logic [L-1:0]                md_r, md_nxt;
  logic [L-1:0]                ra_r, ra_nxt;
  logic [L-1:0]                rb_r, rb_nxt;
  logic [KW-1:0]               k_r, k_nxt;
  logic [CW-1:0]               cnt_r, cnt_nxt;
  logic                        done_r, done_nxt;
  err_t                        err_r, err_nxt;
  logic signed [WORD_BITS-1:0] num_r, num_nxt;
  logic [WORD_BITS-2:0]        den_r, den_nxt;

  logic [NW-1:0] abs_n, abs_d;
  logic [L:0]    sub_uv;
  logic [L-1:0]  diff;
  logic [L:0]    trial_a, trial_b;
  logic          ge_a, ge_b;
  logic          ovf;

  assign abs_n   = n_in[NW-1] ? (~n_in + 1'b1) : n_in;
  assign abs_d   = d_in[NW-1] ? (~d_in + 1'b1) : d_in;
  assign sub_uv  = {1'b0, u_r} - {1'b0, v_r};
  assign diff    = sub_uv[L] ? (~sub_uv[L-1:0] + 1'b1) : sub_uv[L-1:0];
  assign trial_a = {ra_r, mn_r[L-1]};
  assign trial_b = {rb_r, md_r[L-1]};
  assign ge_a    = trial_a >= {1'b0, u_r};
  assign ge_b    = trial_b >= {1'b0, u_r};
  assign ovf     = (md_r > LIM - 1'b1) || (neg_r ? (mn_r > LIM) : (mn_r >= LIM));

  assign rsp.done = done_r;
  assign rsp.err  = err_r;
  assign num      = num_r;
  assign den      = den_r;

  always_comb begin
    st_nxt   = st_r;
    neg_nxt  = neg_r;
    u_nxt    = u_r;
    v_nxt    = v_r;
    mn_nxt   = mn_r;
    md_nxt   = md_r;
    ra_nxt   = ra_r;
    rb_nxt   = rb_r;
    k_nxt    = k_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    err_nxt  = err_r;
    num_nxt  = num_r;
    den_nxt  = den_r;
    case (st_r)
      R_IDLE: begin
        if (start) begin
          if (d_in == '0) begin
            done_nxt = 1'b1;
            err_nxt  = ERR_ZDEN;
            num_nxt  = '0;
            den_nxt  = (WORD_BITS-1)'(1);
          end else if (n_in == '0) begin
            done_nxt = 1'b1;
            err_nxt  = ERR_OK;
            num_nxt  = '0;
            den_nxt  = (WORD_BITS-1)'(1);
          end else begin
            neg_nxt = n_in[NW-1] ^ d_in[NW-1];
            u_nxt   = abs_n[L-1:0];
            v_nxt   = abs_d[L-1:0];
            mn_nxt  = abs_n[L-1:0];
            md_nxt  = abs_d[L-1:0];
            k_nxt   = '0;
            st_nxt  = R_GCD;
          end
        end
      end
      R_GCD: begin
        if (u_r == v_r) begin
          mn_nxt  = mn_r >> k_r;
          md_nxt  = md_r >> k_r;
          ra_nxt  = '0;
          rb_nxt  = '0;
          cnt_nxt = '0;
          st_nxt  = R_DIV;
        end else if (!u_r[0] && !v_r[0]) begin
          u_nxt = u_r >> 1;
          v_nxt = v_r >> 1;
          k_nxt = k_r + 1'b1;
        end else if (!u_r[0]) begin
          u_nxt = u_r >> 1;
        end else if (!v_r[0]) begin
          v_nxt = v_r >> 1;
        end else if (!sub_uv[L]) begin
          u_nxt = diff >> 1;
        end else begin
          v_nxt = diff >> 1;
        end
      end
      R_DIV: begin
        ra_nxt  = ge_a ? L'(trial_a - {1'b0, u_r}) : trial_a[L-1:0];
        rb_nxt  = ge_b ? L'(trial_b - {1'b0, u_r}) : trial_b[L-1:0];
        mn_nxt  = {mn_r[L-2:0], ge_a};
        md_nxt  = {md_r[L-2:0], ge_b};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(L - 1)) begin
          st_nxt = R_CHK;
        end
      end
      R_CHK: begin
        done_nxt = 1'b1;
        st_nxt   = R_IDLE;
        if (ovf) begin
          err_nxt = ERR_OVF;
          num_nxt = '0;
          den_nxt = (WORD_BITS-1)'(1);
        end else begin
          err_nxt = ERR_OK;
          num_nxt = neg_r ? (~mn_r[WORD_BITS-1:0] + 1'b1) : mn_r[WORD_BITS-1:0];
          den_nxt = md_r[WORD_BITS-2:0];
        end
      end
      default: begin
        st_nxt = R_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= R_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r <= neg_nxt;
    u_r   <= u_nxt;
    v_r   <= v_nxt;
    mn_r  <= mn_nxt;
    md_r  <= md_nxt;
    ra_r  <= ra_nxt;
    rb_r  <= rb_nxt;
    k_r   <= k_nxt;
    cnt_r <= cnt_nxt;
    err_r <= err_nxt;
    num_r <= num_nxt;
    den_r <= den_nxt;
  end

endmodule

@@ rtl/rau_back.sv @@
module rau_back #(
  parameter int WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  rau_pkg::item_t  q_item,
  input  logic            q_empty,
  output logic            q_pop,
  rau_out_if.source       out_ch
);
  import rau_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int NW = 2 * W + 1;
  localparam int PW = 2 * W + 2;

  back_state_t             st_r, st_nxt;
  item_t                   it_r, it_nxt;
  logic signed [W-1:0]     an_r, an_nxt;
  logic [W-2:0]            ad_r, ad_nxt;
  logic signed [W-1:0]     bn_r, bn_nxt;
  logic [W-2:0]            bd_r, bd_nxt;
  logic signed [PW-1:0]    p0_r, p0_nxt;
  logic signed [PW-1:0]    p1_r, p1_nxt;
  logic signed [PW-1:0]    p2_r, p2_nxt;
  logic [1:0]              step_r, step_nxt;
  logic                    start_r, start_nxt;
  logic [NW-1:0]           rn_r, rn_nxt;
  logic [NW-1:0]           rd_r, rd_nxt;
  logic signed [W-1:0]     rnum_r, rnum_nxt;
  logic [W-2:0]            rden_r, rden_nxt;
  logic                    rcmp_r, rcmp_nxt;
  err_t                    rerr_r, rerr_nxt;
  logic                    ovalid_r, ovalid_nxt;
  logic signed [NUM_W-1:0] onum_r, onum_nxt;
  logic [DEN_W-1:0]        oden_r, oden_nxt;
  logic                    ocmp_r, ocmp_nxt;
  err_t                    oerr_r, oerr_nxt;

  red_rsp_t                red_rsp;
  logic signed [W-1:0]     red_num;
  logic [W-2:0]            red_den;
  logic signed [W:0]       mx, my;
  logic signed [PW-1:0]    prod;
  logic signed [PW-1:0]    comb_n;

  rau_red #(.WORD_BITS(WORD_BITS)) u_red (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_r),
    .n_in  (rn_r),
    .d_in  (rd_r),
    .rsp   (red_rsp),
    .num   (red_num),
    .den   (red_den)
  );

  assign out_ch.valid        = ovalid_r;
  assign out_ch.res_num      = onum_r;
  assign out_ch.res_den      = oden_r;
  assign out_ch.compare_true = ocmp_r;
  assign out_ch.error_code   = oerr_r;

  always_comb begin
    case (step_r)
      2'd0: begin
        mx = (W+1)'(an_r);
        my = (it_r.op == OP_MUL) ? (W+1)'(bn_r) : (W+1)'(bd_r);
      end
      2'd1: begin
        mx = (W+1)'(bn_r);
        my = (W+1)'(ad_r);
      end
      default: begin
        mx = (W+1)'(ad_r);
        my = (it_r.op == OP_DIV) ? (W+1)'(bn_r) : (W+1)'(bd_r);
      end
    endcase
  end

  assign prod = mx * my;

  always_comb begin
    case (it_r.op)
      OP_ADD:  comb_n = p0_r + p1_r;
      OP_SUB:  comb_n = p0_r - p1_r;
      default: comb_n = p0_r;
    endcase
  end

  always_comb begin
    st_nxt     = st_r;
    it_nxt     = it_r;
    an_nxt     = an_r;
    ad_nxt     = ad_r;
    bn_nxt     = bn_r;
    bd_nxt     = bd_r;
    p0_nxt     = p0_r;
    p1_nxt     = p1_r;
    p2_nxt     = p2_r;
    step_nxt   = step_r;
    start_nxt  = 1'b0;
    rn_nxt     = rn_r;
    rd_nxt     = rd_r;
    rnum_nxt   = rnum_r;
    rden_nxt   = rden_r;
    rcmp_nxt   = rcmp_r;
    rerr_nxt   = rerr_r;
    ovalid_nxt = ovalid_r && !out_ch.ready;
    onum_nxt   = onum_r;
    oden_nxt   = oden_r;
    ocmp_nxt   = ocmp_r;
    oerr_nxt   = oerr_r;
    q_pop      = 1'b0;
    case (st_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          it_nxt   = q_item;
          rnum_nxt = '0;
          rden_nxt = (W-1)'(1);
          rcmp_nxt = 1'b0;
          rerr_nxt = ERR_OK;
          if (q_item.op == OP_NOP) begin
            st_nxt = B_OUT;
          end else begin
            start_nxt = 1'b1;
            rn_nxt    = NW'(q_item.a_num);
            rd_nxt    = NW'(q_item.a_den);
            st_nxt    = B_RA;
          end
        end
      end
      B_RA: begin
        if (red_rsp.done) begin
          an_nxt = red_num;
          ad_nxt = red_den;
          if (red_rsp.err != ERR_OK) begin
            rerr_nxt = red_rsp.err;
            st_nxt   = B_OUT;
          end else if (it_r.op == OP_NORM) begin
            rnum_nxt = red_num;
            rden_nxt = red_den;
            st_nxt   = B_OUT;
          end else begin
            start_nxt = 1'b1;
            rn_nxt    = NW'(it_r.b_num);
            rd_nxt    = NW'(it_r.b_den);
            st_nxt    = B_RB;
          end
        end
      end
      B_RB: begin
        if (red_rsp.done) begin
          bn_nxt = red_num;
          bd_nxt = red_den;
          if (red_rsp.err != ERR_OK) begin
            rerr_nxt = red_rsp.err;
            st_nxt   = B_OUT;
          end else if (it_r.op == OP_EQ) begin
            rcmp_nxt = (red_num == an_r) && (red_den == ad_r);
            st_nxt   = B_OUT;
          end else if (it_r.op == OP_DIV && red_num == '0) begin
            rerr_nxt = ERR_DIVZ;
            st_nxt   = B_OUT;
          end else begin
            step_nxt = '0;
            st_nxt   = B_MUL;
          end
        end
      end
      B_MUL: begin
        case (step_r)
          2'd0:    p0_nxt = prod;
          2'd1:    p1_nxt = prod;
          default: p2_nxt = prod;
        endcase
        step_nxt = step_r + 1'b1;
        if (step_r == 2'd2) begin
          st_nxt = B_CMB;
        end
      end
      B_CMB: begin
        if (it_r.op == OP_LESS) begin
          rcmp_nxt = (p0_r < p1_r);
          st_nxt   = B_OUT;
        end else begin
          start_nxt = 1'b1;
          rn_nxt    = NW'(comb_n);
          rd_nxt    = NW'(p2_r);
          st_nxt    = B_RR;
        end
      end
      B_RR: begin
        if (red_rsp.done) begin
          rerr_nxt = red_rsp.err;
          rnum_nxt = red_num;
          rden_nxt = red_den;
          st_nxt   = B_OUT;
        end
      end
      B_OUT: begin
        if (!ovalid_r) begin
          ovalid_nxt = 1'b1;
          onum_nxt   = NUM_W'(rnum_r);
          oden_nxt   = DEN_W'(rden_r);
          ocmp_nxt   = rcmp_r;
          oerr_nxt   = rerr_r;
          st_nxt     = B_IDLE;
        end
      end
      default: begin
        st_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= B_IDLE;
      step_r   <= '0;
      start_r  <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      step_r   <= step_nxt;
      start_r  <= start_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    it_r   <= it_nxt;
    an_r   <= an_nxt;
    ad_r   <= ad_nxt;
    bn_r   <= bn_nxt;
    bd_r   <= bd_nxt;
    p0_r   <= p0_nxt;
    p1_r   <= p1_nxt;
    p2_r   <= p2_nxt;
    rn_r   <= rn_nxt;
    rd_r   <= rd_nxt;
    rnum_r <= rnum_nxt;
    rden_r <= rden_nxt;
    rcmp_r <= rcmp_nxt;
    rerr_r <= rerr_nxt;
    onum_r <= onum_nxt;
    oden_r <= oden_nxt;
    ocmp_r <= ocmp_nxt;
    oerr_r <= oerr_nxt;
  end

endmodule

@@ rtl/rational_arithmetic_unit.sv @@
// Rational arithmetic unit: exact add, subtract, multiply, divide, less and
// equal on fractions of WORD_BITS-bit integers, results in lowest terms.
// in_ch carries opcode and operands A, B; out_ch carries the reduced result,
// compare flag and error code. Both are valid/ready; a transfer happens when
// both are high. in_ch is taken whenever the two-entry queue has room.
// One item is worked at a time. Each reduction runs a binary GCD at one step
// per cycle and then a shared two-lane restoring divider that divides the
// numerator and denominator by the GCD. Normalize needs one reduction,
// add/sub/mul/div three plus the multiplier products, compares two. Items
// with the unused opcode or a zero denominator (an error) end early; a zero
// numerator skips the GCD and divider of that reduction. The longest items
// are set by the GCD/divider loop, and an input first passes the queue.
// Reset (rst_n low, synchronous) empties the queue, idles both sequencers
// and drops out_ch.valid. While out_ch.ready is low the result holds in the
// output register; the queue keeps accepting until it is full.
`include "assert_macros.svh"

module rational_arithmetic_unit #(
  parameter int WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  rau_in_if.sink     in_ch,
  rau_out_if.source  out_ch
);
  import rau_pkg::*;

  item_t f_item;
  item_t q_item;
  logic  f_push;
  logic  q_full;
  logic  q_pop;
  logic  q_empty;

  rau_front #(.WORD_BITS(WORD_BITS)) u_front (
    .in_ch (in_ch),
    .full  (q_full),
    .push  (f_push),
    .item  (f_item)
  );

  rau_fifo #(.DEPTH(Q_DEPTH)) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push),
    .wdata (f_item),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_item),
    .empty (q_empty)
  );

  rau_back #(.WORD_BITS(WORD_BITS)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_item  (q_item),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

  `RAU_ASSERT(a_err_unit, out_ch.valid && out_ch.error_code != ERR_OK |-> out_ch.res_num == 0 && out_ch.res_den == 1 && !out_ch.compare_true, "error result not 0/1")
  `RAU_ASSERT(a_cmp_unit, out_ch.valid && out_ch.compare_true |-> out_ch.res_num == 0 && out_ch.res_den == 1 && out_ch.error_code == ERR_OK, "compare result not 0/1")
  `RAU_NEVER(a_den_zero, out_ch.valid && out_ch.res_den == 0, "zero denominator on output")
  `RAU_NEVER(a_pop_empty, q_pop && q_empty, "queue read while empty")

endmodule
